>>> design/npf_pkg.sv
// Shared constants and types for the node pool with message FIFO.
package npf_pkg;

  localparam int NODES  = 64;
  localparam int IDX_W  = $clog2(NODES);
  localparam int CNT_W  = IDX_W + 1;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_ENQUEUE = 2'd2,
    REQ_DEQUEUE = 2'd3
  } req_t;

endpackage

>>> design/npf_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
module npf_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 6,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  assign rd = rd_r;

endmodule

>>> design/node_pool_with_message_fifo_core.sv
// Top level of the node pool: LIFO free stack plus FIFO of used nodes.
//
// Input channel (in_valid / in_stall): one request per transaction, with
// in_req_type (allocate, release, enqueue, dequeue) and in_node_index.
// Result channel (out_valid / out_stall): exactly one result transaction per
// request, in request order, carrying the returned node, an overflow flag and
// the queue length after the request.
// Throughput is one request per cycle while results are not stalled; an
// accepted request goes through the input and result registers. The top of
// the free stack and the queue head are prefetched from their RAMs every
// cycle, so each request is one push or pop against registered read data.
// A stalled result holds the result register; the request behind it waits in
// the input register and in_stall rises until the result is taken.
// cfg_wr_en / cfg_wr_data write the pool size (0 taken as 1, values above the
// pool capacity clipped) and reinitialize the pool: free stack holds 0 to
// size-1 with 0 on top, the queue empties. Write it only while idle.
// rst_n (synchronous) does the same with a pool size of 64; no clearing pass
// is needed, per-entry valid bits stand in for the initial stack contents.
module node_pool_with_message_fifo_core
  import npf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_req_type,
  input  logic [IDX_W-1:0] in_node_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_node_valid,
  output logic [IDX_W-1:0] out_result_node,
  output logic             out_overflow,
  output logic             out_queue_empty,
  output logic [CNT_W-1:0] out_queue_length
);

  logic             s1_vld_r, s1_vld_nxt;
  req_t             s1_req_r;
  logic [IDX_W-1:0] s1_idx_r;

  logic [CNT_W-1:0] pool_size_r, pool_size_nxt;
  logic [CNT_W-1:0] free_cnt_r, free_cnt_nxt;
  logic [NODES-1:0] stk_vld_r, stk_vld_nxt;
  logic [CNT_W-1:0] q_cnt_r, q_cnt_nxt;
  logic [IDX_W-1:0] q_head_r, q_head_nxt;
  logic [IDX_W-1:0] q_tail_r, q_tail_nxt;

  logic             stk_we, ring_we;
  logic [IDX_W-1:0] stk_wa, stk_ra, ring_ra;
  logic [IDX_W-1:0] stk_ra_r;
  logic [IDX_W-1:0] stk_rd, ring_rd;
  logic             stk_byp_r, ring_byp_r;
  logic [IDX_W-1:0] byp_data_r;
  logic [IDX_W-1:0] stk_top, ring_top;
  logic [CNT_W-1:0] cfg_size;

  logic             advance, accept;
  logic             res_valid, res_ovf;
  logic [IDX_W-1:0] res_node;

  logic             out_valid_r;
  logic             out_node_valid_r, out_overflow_r, out_queue_empty_r;
  logic [IDX_W-1:0] out_result_node_r;
  logic [CNT_W-1:0] out_queue_length_r;

  assign advance  = s1_vld_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_vld_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_size = CNT_W'(1);
    end else if (cfg_wr_data > CNT_W'(NODES)) begin
      cfg_size = CNT_W'(NODES);
    end else begin
      cfg_size = cfg_wr_data;
    end
  end

  // entry not rewritten since init holds size-1-k
  assign stk_top  = stk_byp_r ? byp_data_r :
                    stk_vld_r[stk_ra_r] ? stk_rd :
                    IDX_W'(pool_size_r - CNT_W'(1) - CNT_W'(stk_ra_r));
  assign ring_top = ring_byp_r ? byp_data_r : ring_rd;

  always_comb begin
    free_cnt_nxt  = free_cnt_r;
    stk_vld_nxt   = stk_vld_r;
    q_cnt_nxt     = q_cnt_r;
    q_head_nxt    = q_head_r;
    q_tail_nxt    = q_tail_r;
    pool_size_nxt = pool_size_r;
    stk_we        = 1'b0;
    ring_we       = 1'b0;
    stk_wa        = free_cnt_r[IDX_W-1:0];
    res_valid     = 1'b0;
    res_node      = '0;
    res_ovf       = 1'b0;
    if (advance) begin
      case (s1_req_r)
        REQ_ALLOC: begin
          if (free_cnt_r != '0) begin
            free_cnt_nxt = free_cnt_r - CNT_W'(1);
            res_valid    = 1'b1;
            res_node     = stk_top;
          end
        end
        REQ_RELEASE: begin
          if (free_cnt_r < CNT_W'(NODES)) begin
            stk_we              = 1'b1;
            stk_vld_nxt[stk_wa] = 1'b1;
            free_cnt_nxt        = free_cnt_r + CNT_W'(1);
          end else begin
            res_ovf = 1'b1;
          end
        end
        REQ_ENQUEUE: begin
          if (q_cnt_r < CNT_W'(NODES)) begin
            ring_we    = 1'b1;
            q_tail_nxt = (q_tail_r == IDX_W'(NODES - 1)) ? '0 : q_tail_r + IDX_W'(1);
            q_cnt_nxt  = q_cnt_r + CNT_W'(1);
          end else begin
            res_ovf = 1'b1;
          end
        end
        REQ_DEQUEUE: begin
          if (q_cnt_r != '0) begin
            res_valid  = 1'b1;
            res_node   = ring_top;
            q_head_nxt = (q_head_r == IDX_W'(NODES - 1)) ? '0 : q_head_r + IDX_W'(1);
            q_cnt_nxt  = q_cnt_r - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
    if (cfg_wr_en) begin
      pool_size_nxt = cfg_size;
      free_cnt_nxt  = cfg_size;
      stk_vld_nxt   = '0;
      q_cnt_nxt     = '0;
      q_head_nxt    = '0;
      q_tail_nxt    = '0;
    end
  end

  assign stk_ra  = IDX_W'(free_cnt_nxt - CNT_W'(1));
  assign ring_ra = q_head_nxt;

  npf_ram #(.DEPTH(NODES), .WIDTH(IDX_W)) u_stk_ram (
    .clk (clk),
    .we  (stk_we),
    .wa  (stk_wa),
    .wd  (s1_idx_r),
    .ra  (stk_ra),
    .rd  (stk_rd)
  );

  npf_ram #(.DEPTH(NODES), .WIDTH(IDX_W)) u_ring_ram (
    .clk (clk),
    .we  (ring_we),
    .wa  (q_tail_r),
    .wd  (s1_idx_r),
    .ra  (ring_ra),
    .rd  (ring_rd)
  );

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (advance) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pool_size_r <= CNT_W'(NODES);
      free_cnt_r  <= CNT_W'(NODES);
      stk_vld_r   <= '0;
      q_cnt_r     <= '0;
      q_head_r    <= '0;
      q_tail_r    <= '0;
      stk_byp_r   <= 1'b0;
      ring_byp_r  <= 1'b0;
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      pool_size_r <= pool_size_nxt;
      free_cnt_r  <= free_cnt_nxt;
      stk_vld_r   <= stk_vld_nxt;
      q_cnt_r     <= q_cnt_nxt;
      q_head_r    <= q_head_nxt;
      q_tail_r    <= q_tail_nxt;
      stk_byp_r   <= stk_we && (stk_wa == stk_ra);
      ring_byp_r  <= ring_we && (q_tail_r == ring_ra);
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    stk_ra_r   <= stk_ra;
    byp_data_r <= s1_idx_r;
    if (accept) begin
      s1_req_r <= req_t'(in_req_type);
      s1_idx_r <= in_node_index;
    end
    if (advance) begin
      out_node_valid_r   <= res_valid;
      out_result_node_r  <= res_node;
      out_overflow_r     <= res_ovf;
      out_queue_empty_r  <= (q_cnt_nxt == '0);
      out_queue_length_r <= q_cnt_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_node_valid   = out_node_valid_r;
  assign out_result_node  = out_result_node_r;
  assign out_overflow     = out_overflow_r;
  assign out_queue_empty  = out_queue_empty_r;
  assign out_queue_length = out_queue_length_r;

endmodule
